[sv/cdq_pkg.sv]
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types and constants of the circular deque unit.
// ----------------------------------------------------------------------------
package cdq_pkg;

  localparam int KIND_W  = 3;
  localparam int VALUE_W = 32;
  localparam int CAP_W   = 10;

  localparam logic [CAP_W-1:0] CAP_RESET = 10'd1023;

  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_REAR  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POP_REAR   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_QUERY      = 3'd4;

  localparam logic signed [VALUE_W-1:0] EMPTY_MARK = -32'sd1;

  typedef struct packed {
    logic capture;
    logic exec;
    logic read;
    logic load;
  } cdq_cmd_t;

  typedef struct packed {
    logic out_hold;
  } cdq_status_t;

endpackage

[sv/circular_deque_ring_buffer_unit.sv]
// ----------------------------------------------------------------------------
// circular_deque_ring_buffer_unit
// Each item passes through the controller's capture, update, memory read and
// output load steps around the single-write ring store; in_stall holds new
// items off until the previous result is loaded, which waits on out_stall.
// Reset clears head and tail, sets capacity to 1023; store contents undefined.
// ----------------------------------------------------------------------------
module circular_deque_ring_buffer_unit
  import cdq_pkg::*;
#(
  parameter int RING_SLOTS = 1024
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CAP_W-1:0]          cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [KIND_W-1:0]         kind,
  input  logic signed [VALUE_W-1:0] value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      ok,
  output logic signed [VALUE_W-1:0] front_value,
  output logic signed [VALUE_W-1:0] rear_value,
  output logic                      is_empty,
  output logic                      is_full
);

  cdq_cmd_t    cmd;
  cdq_status_t status;

  cdq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  cdq_datapath #(
    .RING_SLOTS (RING_SLOTS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .kind        (kind),
    .value       (value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .ok          (ok),
    .front_value (front_value),
    .rear_value  (rear_value),
    .is_empty    (is_empty),
    .is_full     (is_full)
  );

endmodule

[sv/cdq_ctrl.sv]
// ----------------------------------------------------------------------------
// cdq_ctrl
// Sequencer: capture an item, update the ring, read both ends, load result.
// ----------------------------------------------------------------------------
module cdq_ctrl
  import cdq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  cdq_status_t status,
  output cdq_cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd         = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = ST_READ;
      end
      ST_READ: begin
        cmd.read   = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!status.out_hold) begin
          cmd.load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign in_stall = (state != ST_IDLE);

endmodule

[sv/cdq_datapath.sv]
// ----------------------------------------------------------------------------
// cdq_datapath
// Ring store, head and tail indices, ring size and the output register.
// ----------------------------------------------------------------------------
module cdq_datapath
  import cdq_pkg::*;
#(
  parameter int RING_SLOTS = 1024
) (
  input  logic                      clk,
  input  logic                      rst,
  input  cdq_cmd_t                  cmd,
  output cdq_status_t               status,
  input  logic                      cfg_we,
  input  logic [CAP_W-1:0]          cfg_data,
  input  logic [KIND_W-1:0]         kind,
  input  logic signed [VALUE_W-1:0] value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      ok,
  output logic signed [VALUE_W-1:0] front_value,
  output logic signed [VALUE_W-1:0] rear_value,
  output logic                      is_empty,
  output logic                      is_full
);

  localparam int IDX_W  = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
  localparam int SIZE_W = IDX_W + 1;
  localparam int RESET_CAP = (int'(CAP_RESET) > RING_SLOTS - 1) ? RING_SLOTS - 1
                                                                  : int'(CAP_RESET);
  localparam logic [SIZE_W-1:0] RESET_N = SIZE_W'(RESET_CAP + 1);
  localparam logic [31:0] MAX_CAP = 32'(RING_SLOTS - 1);

  logic signed [VALUE_W-1:0] mem [RING_SLOTS];

  logic [IDX_W-1:0]          head;
  logic [IDX_W-1:0]          tail;
  logic [SIZE_W-1:0]         ring_n;
  logic [KIND_W-1:0]         kind_q;
  logic signed [VALUE_W-1:0] value_q;
  logic                      ok_q;
  logic signed [VALUE_W-1:0] front_q;
  logic signed [VALUE_W-1:0] rear_q;
  logic                      empty_q;
  logic                      full_q;

  logic [IDX_W-1:0]          head_inc;
  logic [IDX_W-1:0]          head_dec;
  logic [IDX_W-1:0]          tail_inc;
  logic [IDX_W-1:0]          tail_dec;
  logic [IDX_W-1:0]          n_last;
  logic                      empty_now;
  logic                      full_now;
  logic [IDX_W-1:0]          head_next;
  logic [IDX_W-1:0]          tail_next;
  logic                      ok_next;
  logic                      wr_en;
  logic [IDX_W-1:0]          wr_addr;
  logic [31:0]               cap32;
  logic [SIZE_W-1:0]         cfg_n;

  assign n_last = IDX_W'(ring_n - SIZE_W'(1));

  always_comb begin
    head_inc = (({1'b0, head} + SIZE_W'(1)) >= ring_n) ? '0 : IDX_W'(head + 1'b1);
    tail_inc = (({1'b0, tail} + SIZE_W'(1)) >= ring_n) ? '0 : IDX_W'(tail + 1'b1);
    head_dec = (head == '0 || {1'b0, head} >= ring_n) ? n_last : IDX_W'(head - 1'b1);
    tail_dec = (tail == '0 || {1'b0, tail} >= ring_n) ? n_last : IDX_W'(tail - 1'b1);
    empty_now = (head == tail);
    full_now  = (tail_inc == head);
  end

  always_comb begin
    head_next = head;
    tail_next = tail;
    ok_next   = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = tail;
    case (kind_q)
      KIND_PUSH_FRONT: begin
        if (!full_now) begin
          head_next = head_dec;
          wr_en     = 1'b1;
          wr_addr   = head_dec;
          ok_next   = 1'b1;
        end
      end
      KIND_PUSH_REAR: begin
        if (!full_now) begin
          tail_next = tail_inc;
          wr_en     = 1'b1;
          wr_addr   = tail;
          ok_next   = 1'b1;
        end
      end
      KIND_POP_FRONT: begin
        if (!empty_now) begin
          head_next = head_inc;
          ok_next   = 1'b1;
        end
      end
      KIND_POP_REAR: begin
        if (!empty_now) begin
          tail_next = tail_dec;
          ok_next   = 1'b1;
        end
      end
      KIND_QUERY: begin
        ok_next = 1'b1;
      end
      default: begin
        ok_next = 1'b0;
      end
    endcase
  end

  always_comb begin
    cap32 = 32'(cfg_data);
    if (cap32 == 32'd0) begin
      cfg_n = SIZE_W'(2);
    end else if (cap32 > MAX_CAP) begin
      cfg_n = SIZE_W'(RING_SLOTS);
    end else begin
      cfg_n = SIZE_W'(cap32 + 32'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head   <= '0;
      tail   <= '0;
      ring_n <= RESET_N;
    end else if (cfg_we) begin
      head   <= '0;
      tail   <= '0;
      ring_n <= cfg_n;
    end else if (cmd.exec) begin
      head <= head_next;
      tail <= tail_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      mem[wr_addr] <= value_q;
    end
    if (cmd.read) begin
      front_q <= mem[head];
      rear_q  <= mem[tail_dec];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_q  <= kind;
      value_q <= value;
    end
    if (cmd.exec) begin
      ok_q <= ok_next;
    end
    if (cmd.read) begin
      empty_q <= empty_now;
      full_q  <= full_now;
    end
    if (cmd.load) begin
      ok          <= ok_q;
      front_value <= empty_q ? EMPTY_MARK : front_q;
      rear_value  <= empty_q ? EMPTY_MARK : rear_q;
      is_empty    <= empty_q;
      is_full     <= full_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign status.out_hold = out_valid && out_stall;

endmodule

[sv/cdq_checker.sv]
// ----------------------------------------------------------------------------
// cdq_checker
// Port-level checks of the circular deque unit.
// ----------------------------------------------------------------------------
module cdq_checker
  import cdq_pkg::*;
(
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic                      ok,
  input logic signed [VALUE_W-1:0] front_value,
  input logic signed [VALUE_W-1:0] rear_value,
  input logic                      is_empty,
  input logic                      is_full
);

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in flight");

  a_empty_mark: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_empty |-> front_value == EMPTY_MARK && rear_value == EMPTY_MARK)
    else $error("empty deque reports an item");

  a_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(is_empty && is_full))
    else $error("deque both empty and full");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(ok) && $stable(front_value)
      && $stable(rear_value) && $stable(is_empty) && $stable(is_full))
    else $error("stalled item changed");

endmodule

bind circular_deque_ring_buffer_unit cdq_checker u_cdq_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .ok          (ok),
  .front_value (front_value),
  .rear_value  (rear_value),
  .is_empty    (is_empty),
  .is_full     (is_full)
);

[tb/circular_deque_checker.sv]
// ----------------------------------------------------------------------------
// circular_deque_checker
// Watches the configuration port and both item channels of the deque unit.
// Keeps its own ring, head and tail to work out the result of every accepted
// operation, then compares each returned result field by field, in order.
// ----------------------------------------------------------------------------
module circular_deque_checker
  import cdq_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CAP_W-1:0]          cfg_data,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [KIND_W-1:0]         kind,
  input  logic signed [VALUE_W-1:0] value,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic                      ok,
  input  logic signed [VALUE_W-1:0] front_value,
  input  logic signed [VALUE_W-1:0] rear_value,
  input  logic                      is_empty,
  input  logic                      is_full,
  output int                        pending,
  output int                        errors
);

  localparam int SLOTS   = 1024;
  localparam int CAP_MAX = SLOTS - 1;

  typedef struct packed {
    logic                      ok;
    logic signed [VALUE_W-1:0] front_value;
    logic signed [VALUE_W-1:0] rear_value;
    logic                      is_empty;
    logic                      is_full;
  } deque_view_t;

  logic [VALUE_W-1:0] slot_mem [SLOTS];
  int unsigned        head_ptr;
  int unsigned        tail_ptr;
  logic [CAP_W-1:0]   capacity;
  deque_view_t        awaited_views [$];
  int                 mismatches = 0;

  function automatic int unsigned ring_len(input logic [CAP_W-1:0] cap);
    int unsigned c;
    c = cap;
    if (c < 1) c = 1;
    if (c > CAP_MAX) c = CAP_MAX;
    return c + 1;
  endfunction

  function automatic int unsigned next_slot(input int unsigned i, input int unsigned n);
    return (i + 1 >= n) ? 0 : i + 1;
  endfunction

  function automatic int unsigned prev_slot(input int unsigned i, input int unsigned n);
    return (i == 0 || i >= n) ? n - 1 : i - 1;
  endfunction

  task automatic apply_op(input logic [KIND_W-1:0] k, input logic [VALUE_W-1:0] v,
                          output deque_view_t res);
    int unsigned n;
    logic        empty_now;
    logic        full_now;
    n         = ring_len(capacity);
    empty_now = (head_ptr == tail_ptr);
    full_now  = (next_slot(tail_ptr, n) == head_ptr);
    res       = '0;
    case (k)
      KIND_PUSH_FRONT: begin
        if (!full_now) begin
          head_ptr           = prev_slot(head_ptr, n);
          slot_mem[head_ptr] = v;
          res.ok             = 1'b1;
        end
      end
      KIND_PUSH_REAR: begin
        if (!full_now) begin
          slot_mem[tail_ptr] = v;
          tail_ptr           = next_slot(tail_ptr, n);
          res.ok             = 1'b1;
        end
      end
      KIND_POP_FRONT: begin
        if (!empty_now) begin
          head_ptr = next_slot(head_ptr, n);
          res.ok   = 1'b1;
        end
      end
      KIND_POP_REAR: begin
        if (!empty_now) begin
          tail_ptr = prev_slot(tail_ptr, n);
          res.ok   = 1'b1;
        end
      end
      KIND_QUERY: begin
        res.ok = 1'b1;
      end
      default: begin
      end
    endcase
    res.is_empty = (head_ptr == tail_ptr);
    res.is_full  = (next_slot(tail_ptr, n) == head_ptr);
    if (res.is_empty) begin
      res.front_value = EMPTY_MARK;
      res.rear_value  = EMPTY_MARK;
    end else begin
      res.front_value = slot_mem[head_ptr];
      res.rear_value  = slot_mem[prev_slot(tail_ptr, n)];
    end
  endtask

  task automatic flag_mismatch(input string field,
                               input logic signed [VALUE_W-1:0] want_v,
                               input logic signed [VALUE_W-1:0] got_v);
    mismatches++;
    $error("%s: expected %0d, got %0d", field, want_v, got_v);
  endtask

  always @(posedge clk) begin
    deque_view_t want;
    if (rst) begin
      head_ptr = 0;
      tail_ptr = 0;
      capacity = CAP_RESET;
      awaited_views.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_views.size() == 0) begin
          mismatches++;
          $error("result item with no operation outstanding");
        end else begin
          want = awaited_views.pop_front();
          if (ok !== want.ok) flag_mismatch("ok", want.ok, ok);
          if (front_value !== want.front_value)
            flag_mismatch("front_value", want.front_value, front_value);
          if (rear_value !== want.rear_value)
            flag_mismatch("rear_value", want.rear_value, rear_value);
          if (is_empty !== want.is_empty) flag_mismatch("is_empty", want.is_empty, is_empty);
          if (is_full !== want.is_full) flag_mismatch("is_full", want.is_full, is_full);
        end
      end
      if (cfg_we) begin
        capacity = cfg_data;
        head_ptr = 0;
        tail_ptr = 0;
      end
      if (in_valid && !in_stall) begin
        apply_op(kind, value, want);
        awaited_views.push_back(want);
      end
    end
    pending <= awaited_views.size();
    errors  <= mismatches;
  end

endmodule

[tb/tb_circular_deque_ring_buffer_unit.sv]
// ----------------------------------------------------------------------------
// tb_circular_deque_ring_buffer_unit
// Drives directed and random deque operations across a series of capacities,
// with random gaps and stalls on both channels and one long output hold-off.
// Results are checked by circular_deque_checker beside the unit.
// ----------------------------------------------------------------------------
module tb_circular_deque_ring_buffer_unit;
  import cdq_pkg::*;

  localparam int PHASES          = 12;
  localparam int ITEMS_PER_PHASE = 52;
  localparam int PRESSURE_PHASE  = 3;
  localparam int HOLD_CYCLES     = 400;
  localparam int IDLE_LIMIT      = 4000;
  localparam logic [KIND_W-1:0] KIND_LAST = '1;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      cfg_we;
  logic [CAP_W-1:0]          cfg_data;
  logic                      in_valid;
  logic                      in_stall;
  logic [KIND_W-1:0]         kind;
  logic signed [VALUE_W-1:0] value;
  logic                      out_valid;
  logic                      out_stall;
  logic                      ok;
  logic signed [VALUE_W-1:0] front_value;
  logic signed [VALUE_W-1:0] rear_value;
  logic                      is_empty;
  logic                      is_full;
  int                        pending;
  int                        errors;
  int                        idle_cycles = 0;
  bit                        no_gaps = 1'b0;
  bit                        hold_req = 1'b0;

  logic [CAP_W-1:0] phase_caps [PHASES] = '{10'd1, 10'd2, 10'd0, 10'd1023, 10'd3, 10'd5,
                                            10'd1022, 10'd8, 10'd4, 10'd13, 10'd0, 10'd1};

  always #4 clk = ~clk;

  circular_deque_ring_buffer_unit dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .value      (value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .ok         (ok),
    .front_value(front_value),
    .rear_value (rear_value),
    .is_empty   (is_empty),
    .is_full    (is_full)
  );

  circular_deque_checker watch (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .value      (value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .ok         (ok),
    .front_value(front_value),
    .rear_value (rear_value),
    .is_empty   (is_empty),
    .is_full    (is_full),
    .pending    (pending),
    .errors     (errors)
  );

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("circular_deque_ring_buffer_unit regression: fail");
      $finish;
    end
  end

  initial begin
    int waits;
    out_stall = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      waits = no_gaps ? 0 : $urandom_range(0, 19);
      if (waits != 0) begin
        out_stall <= 1'b1;
        repeat (waits) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic offer(input logic [KIND_W-1:0] k, input logic [VALUE_W-1:0] v);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    value    <= v;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] c);
    cfg_we   <= 1'b1;
    cfg_data <= c;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  initial begin
    int                 eff;
    int                 seg;
    int                 r;
    bit                 filling;
    logic [KIND_W-1:0]  op;
    logic [VALUE_W-1:0] data;
    rst      = 1'b1;
    cfg_we   = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    kind     = KIND_QUERY;
    value    = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // empty deque at reset capacity: refused pops, unknown kinds, then pushes and pops at both ends
    offer(KIND_QUERY, '0);
    offer(KIND_POP_FRONT, 32'h1234_5678);
    offer(KIND_POP_REAR, '0);
    for (int k = int'(KIND_QUERY) + 1; k <= int'(KIND_LAST); k++) offer(KIND_W'(k), '1);
    offer(KIND_PUSH_FRONT, 32'h7fff_ffff);
    offer(KIND_PUSH_REAR, 32'h8000_0000);
    offer(KIND_PUSH_FRONT, '0);
    offer(KIND_PUSH_REAR, '1);
    offer(KIND_LAST, 32'h5a5a_5a5a);
    offer(KIND_POP_FRONT, '0);
    offer(KIND_POP_REAR, '0);
    offer(KIND_POP_FRONT, '0);
    offer(KIND_POP_REAR, '0);

    // zero capacity holds one item
    settle();
    write_capacity('0);
    offer(KIND_PUSH_REAR, 32'hdead_beef);
    offer(KIND_PUSH_FRONT, 32'h0000_0001);
    offer(KIND_QUERY, '0);
    offer(KIND_POP_REAR, '0);
    offer(KIND_POP_FRONT, '0);

    // capacity write drops held items
    offer(KIND_PUSH_FRONT, 32'hcafe_f00d);
    settle();
    write_capacity(10'd1023);
    offer(KIND_QUERY, '0);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      write_capacity(phase_caps[p]);
      no_gaps  = (p == PRESSURE_PHASE) || ($urandom_range(0, 3) == 0);
      hold_req = (p == PRESSURE_PHASE);
      eff      = (phase_caps[p] == 0) ? 1 : int'(phase_caps[p]);
      seg      = (eff > 28) ? 30 : eff + 2;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        filling = ((i / seg) % 2 == 0);
        r = $urandom_range(0, 99);
        if (r < 4) op = KIND_W'($urandom_range(int'(KIND_QUERY) + 1, int'(KIND_LAST)));
        else if (r < 10) op = KIND_QUERY;
        else if (r < (filling ? 75 : 30))
          op = $urandom_range(0, 1) ? KIND_PUSH_REAR : KIND_PUSH_FRONT;
        else op = $urandom_range(0, 1) ? KIND_POP_REAR : KIND_POP_FRONT;
        case ($urandom_range(0, 15))
          0: data = '0;
          1: data = '1;
          2: data = 32'h7fff_ffff;
          3: data = 32'h8000_0000;
          default: data = $urandom;
        endcase
        offer(op, data);
      end
    end

    settle();
    if (errors == 0) begin
      $display("circular_deque_ring_buffer_unit regression: pass");
    end else begin
      $display("circular_deque_ring_buffer_unit regression: fail");
    end
    $finish;
  end

endmodule
